FILE: design/stok_pkg.sv
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types, codes and character tables for the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

    // Token kinds
    localparam logic [4:0] KIND_END       = 5'd0;
    localparam logic [4:0] KIND_ASSIGN    = 5'd1;
    localparam logic [4:0] KIND_PLUS      = 5'd2;
    localparam logic [4:0] KIND_MINUS     = 5'd3;
    localparam logic [4:0] KIND_STAR      = 5'd4;
    localparam logic [4:0] KIND_SLASH     = 5'd5;
    localparam logic [4:0] KIND_LPAREN    = 5'd6;
    localparam logic [4:0] KIND_RPAREN    = 5'd7;
    localparam logic [4:0] KIND_SEMICOLON = 5'd8;
    localparam logic [4:0] KIND_COMMA     = 5'd9;
    localparam logic [4:0] KIND_STRING    = 5'd10;
    localparam logic [4:0] KIND_INT       = 5'd11;
    localparam logic [4:0] KIND_FLOAT     = 5'd12;
    localparam logic [4:0] KIND_IDENT     = 5'd13;
    localparam logic [4:0] KIND_KW_BASE   = 5'd14;
    localparam logic [4:0] KIND_UNKNOWN   = 5'd19;
    localparam logic [4:0] KIND_NONE      = 5'd0;

    localparam int KW_COUNT = 5;

    // Characters with a role of their own
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // Lexer modes, one-hot
    typedef enum logic [5:0] {
        MODE_IDLE    = 6'b000001,
        MODE_COMMENT = 6'b000010,
        MODE_STRING  = 6'b000100,
        MODE_INT     = 6'b001000,
        MODE_FLOAT   = 6'b010000,
        MODE_IDENT   = 6'b100000
    } mode_t;

    // One result item
    typedef struct packed {
        logic [4:0]  kind;
        logic [19:0] start;
        logic [19:0] length;
        logic [31:0] value;
        logic [20:0] line;
        logic        last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // Operator kind for a byte, KIND_NONE if it is no operator
    function automatic logic [4:0] op_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h3D:   k = KIND_ASSIGN;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h3B:   k = KIND_SEMICOLON;
            8'h2C:   k = KIND_COMMA;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    // Keyword spelling, last character in the lowest byte
    function automatic logic [47:0] kw_text(input int k);
        logic [47:0] t;
        case (k)
            0:       t = 48'("let");
            1:       t = 48'("print");
            2:       t = 48'("int");
            3:       t = 48'("float");
            4:       t = 48'("string");
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] kw_len(input int k);
        logic [2:0] n;
        case (k)
            0:       n = 3'd3;
            1:       n = 3'd5;
            2:       n = 3'd3;
            3:       n = 3'd5;
            4:       n = 3'd6;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Character of keyword k at position idx (idx below its length)
    function automatic logic [7:0] kw_char(input int k, input logic [2:0] idx);
        logic [47:0] t;
        int          sh;
        t  = kw_text(k);
        sh = (int'(kw_len(k)) - 1 - int'(idx)) * 8;
        if (sh < 0) begin
            return 8'h00;
        end
        t = t >> sh;
        return t[7:0];
    endfunction

    // Drop the keywords that no longer match after character c at idx
    function automatic logic [4:0] kw_update(input logic [4:0] flags, input logic [31:0] idx,
                                             input logic [7:0] c);
        logic [4:0] res;
        res = flags;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (!((idx < 32'(kw_len(k))) && (kw_char(k, idx[2:0]) == c))) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

endpackage

FILE: design/source_tokenizer_core.sv
// ----------------------------------------------------------------------------
// source_tokenizer_core
// Streaming lexer: source bytes in, tokens with kind, offset, length, value
// and line out.
//
// One source byte is taken per cycle on the slave side (s_tdata = byte,
// s_tuser = end-of-source mark) and lexed in the same cycle against the
// lexer state registers; each byte yields zero, one or two tokens, which go
// into a four-entry output queue. s_tready is high while the queue has at
// least two free entries, so a byte is taken every cycle as long as the
// master side drains about one token per cycle; the output port (one token
// a cycle) sets the sustained rate for token-dense text. An end mark
// flushes any pending token, gives the end token and returns the lexer to
// its reset state. Bytes past MAX_INPUT_BYTES-1 are dropped without result.
// ----------------------------------------------------------------------------
module source_tokenizer_core
    import stok_pkg::*;
#(
    parameter int MAX_INPUT_BYTES = 1048576
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [19:0] token_start, [39:20] token_length,
                                   // [71:40] int_value, [92:72] line_number, zero pad
    output logic [4:0]  m_tuser,   // [4:0] token_kind
    output logic        m_tlast    // last_result
);

    localparam int POS_W      = $clog2(MAX_INPUT_BYTES);
    localparam int LINE_W     = $clog2(MAX_INPUT_BYTES + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_INPUT_BYTES - 1);

    // Lexer state
    mode_t             mode_reg,  mode_next;
    logic              slash_reg, slash_next;
    logic [POS_W-1:0]  tb_reg,    tb_next;
    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [LINE_W-1:0] line_reg,  line_next;
    logic [31:0]       acc_reg,   acc_next;
    logic [4:0]        flags_reg, flags_next;

    // Output queue
    token_t            fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next, wr_ptr1;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    logic              in_fire, end_fire, proc, pop;
    logic [7:0]        c;
    logic [POS_W-1:0]  len;
    logic [31:0]       len32, tb32, pos32, pos1_32, line32;
    logic [4:0]        op, ident_kind;
    logic              mode_pending, do_idle;
    logic              pre_v, sec_v, w0, w1;
    token_t            pre_tok, sec_tok, pend_tok, slash_tok, slot0, slot1, head;

    assign in_fire  = s_tvalid && s_tready;
    assign end_fire = in_fire && s_tuser[0];
    assign proc     = in_fire && !s_tuser[0] && (pos_reg < POS_LIMIT);
    assign c        = s_tdata;
    assign op       = op_kind(c);

    assign len     = pos_reg - tb_reg;
    assign len32   = 32'(len);
    assign tb32    = 32'(tb_reg);
    assign pos32   = 32'(pos_reg);
    assign pos1_32 = 32'(pos_reg) + 32'd1;
    assign line32  = 32'(line_reg);

    assign mode_pending = (mode_reg == MODE_STRING) || (mode_reg == MODE_INT) ||
                          (mode_reg == MODE_FLOAT)  || (mode_reg == MODE_IDENT);

    // Resolve identifier against the keywords, lowest index first
    always_comb
    begin
        ident_kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (flags_reg[k] && (len32 == 32'(kw_len(k)))) begin
                ident_kind = KIND_KW_BASE + 5'(k);
            end
        end
    end

    // Build the pending token and the held slash
    always_comb
    begin
        pend_tok        = '0;
        pend_tok.start  = tb32[19:0];
        pend_tok.length = len32[19:0];
        pend_tok.line   = line32[20:0];
        case (mode_reg)
            MODE_STRING: pend_tok.kind = KIND_STRING;
            MODE_INT:
            begin
                pend_tok.kind  = KIND_INT;
                pend_tok.value = acc_reg;
            end
            MODE_FLOAT:  pend_tok.kind = KIND_FLOAT;
            MODE_IDENT:  pend_tok.kind = ident_kind;
            default:     pend_tok.kind = KIND_END;
        endcase

        slash_tok        = '0;
        slash_tok.kind   = KIND_SLASH;
        slash_tok.start  = tb32[19:0];
        slash_tok.length = 20'd1;
        slash_tok.line   = line32[20:0];
    end

    // Lex one byte: next state and up to two tokens
    always_comb
    begin
        mode_next  = mode_reg;
        slash_next = slash_reg;
        tb_next    = tb_reg;
        pos_next   = pos_reg;
        line_next  = line_reg;
        acc_next   = acc_reg;
        flags_next = flags_reg;
        pre_v      = 1'b0;
        pre_tok    = pend_tok;
        sec_v      = 1'b0;
        do_idle    = 1'b0;

        sec_tok        = '0;
        sec_tok.start  = pos32[19:0];
        sec_tok.length = 20'd1;
        sec_tok.line   = line32[20:0];

        if (end_fire) begin
            // Flush, emit end token, return to reset state
            if (slash_reg) begin
                pre_v   = 1'b1;
                pre_tok = slash_tok;
            end else begin
                pre_v = mode_pending;
            end
            sec_v          = 1'b1;
            sec_tok.kind   = KIND_END;
            sec_tok.length = 20'd0;
            mode_next      = MODE_IDLE;
            slash_next     = 1'b0;
            tb_next        = '0;
            pos_next       = '0;
            line_next      = LINE_W'(1);
            acc_next       = '0;
            flags_next     = 5'h1F;
        end else if (proc) begin
            pos_next   = pos_reg + POS_W'(1);
            slash_next = 1'b0;
            if (slash_reg) begin
                if (c == CH_SLASH) begin
                    mode_next = MODE_COMMENT;
                end else begin
                    pre_v   = 1'b1;
                    pre_tok = slash_tok;
                    do_idle = 1'b1;
                end
            end else begin
                case (mode_reg)
                    MODE_COMMENT:
                    begin
                        if (c == CH_LF) begin
                            do_idle = 1'b1;
                        end
                    end
                    MODE_STRING:
                    begin
                        if (c == CH_QUOTE) begin
                            pre_v     = 1'b1;
                            mode_next = MODE_IDLE;
                        end else if (c == CH_LF) begin
                            line_next = line_reg + LINE_W'(1);
                        end
                    end
                    MODE_INT:
                    begin
                        if (is_digit(c)) begin
                            acc_next = (acc_reg << 3) + (acc_reg << 1) + 32'(c[3:0]);
                        end else if (c == CH_DOT) begin
                            mode_next = MODE_FLOAT;
                        end else begin
                            pre_v   = 1'b1;
                            do_idle = 1'b1;
                        end
                    end
                    MODE_FLOAT:
                    begin
                        if (!is_digit(c)) begin
                            pre_v   = 1'b1;
                            do_idle = 1'b1;
                        end
                    end
                    MODE_IDENT:
                    begin
                        if (is_word(c)) begin
                            flags_next = kw_update(flags_reg, len32, c);
                        end else begin
                            pre_v   = 1'b1;
                            do_idle = 1'b1;
                        end
                    end
                    default: do_idle = 1'b1;
                endcase
            end

            // Lex the byte from idle
            if (do_idle) begin
                mode_next = MODE_IDLE;
                if (is_space(c)) begin
                    if (c == CH_LF) begin
                        line_next = line_reg + LINE_W'(1);
                    end
                end else if (c == CH_SLASH) begin
                    slash_next = 1'b1;
                    tb_next    = pos_reg;
                end else if (op != KIND_NONE) begin
                    sec_v        = 1'b1;
                    sec_tok.kind = op;
                end else if (c == CH_QUOTE) begin
                    mode_next = MODE_STRING;
                    tb_next   = pos1_32[POS_W-1:0];
                end else if (is_digit(c)) begin
                    mode_next = MODE_INT;
                    tb_next   = pos_reg;
                    acc_next  = 32'(c[3:0]);
                end else if (is_alpha(c) || (c == CH_UNDER)) begin
                    mode_next  = MODE_IDENT;
                    tb_next    = pos_reg;
                    flags_next = kw_update(5'h1F, 32'd0, c);
                end else begin
                    sec_v        = 1'b1;
                    sec_tok.kind = KIND_UNKNOWN;
                end
            end
        end
    end

    // Lexer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            slash_reg <= 1'b0;
            tb_reg    <= '0;
            pos_reg   <= '0;
            line_reg  <= LINE_W'(1);
            acc_reg   <= '0;
            flags_reg <= 5'h1F;
        end else begin
            mode_reg  <= mode_next;
            slash_reg <= slash_next;
            tb_reg    <= tb_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            acc_reg   <= acc_next;
            flags_reg <= flags_next;
        end
    end

    // Order the tokens of this byte into queue slots
    always_comb
    begin
        w0         = pre_v || sec_v;
        w1         = pre_v && sec_v;
        slot0      = pre_v ? pre_tok : sec_tok;
        slot0.last = !w1;
        slot1      = sec_tok;
        slot1.last = 1'b1;
    end

    assign wr_ptr1 = wr_ptr_reg + PTR_W'(1);
    assign pop     = m_tvalid && m_tready;

    // Write queue entries
    always_ff @(posedge clk)
    begin
        if (w0) begin
            fifo_mem[wr_ptr_reg] <= slot0;
        end
        if (w1) begin
            fifo_mem[wr_ptr1] <= slot1;
        end
    end

    // Advance queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(w0) + PTR_W'(w1);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(w0) + CNT_W'(w1) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Drive the ports
    assign s_tready = count_reg <= CNT_W'(FIFO_DEPTH - 2);
    assign m_tvalid = count_reg != '0;
    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tdata  = {3'b000, head.line, head.value, head.length, head.start};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

`ifndef SYNTH
    // Queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("output queue overfilled");

    // A held slash only stands with no token in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        slash_reg |-> (mode_reg == MODE_IDLE))
        else $error("slash held while a token is open");

    // End mark returns the lexer to its reset position and line
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0]) |=> ((pos_reg == '0) && (line_reg == LINE_W'(1))))
        else $error("end mark did not restart the lexer");
`endif

endmodule

FILE: bench/tb_source_tokenizer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_source_tokenizer_core
// Self-checking bench for the streaming source tokenizer.
//
// Source bytes go in as stream requests, one byte or one end mark each. A
// scoreboard class runs its own lexer over every accepted request. It queues
// the tokens that the request should give and compares each token taken on
// the master side, field by field, against the oldest one queued. A short
// directed source comes first: every operator, the lone slash, a trailing and
// a second dot, a non-ASCII byte, a comment, an unterminated string and an
// empty source. Random sources follow, mostly well-formed token runs with
// noise between them, in four idling phases. The byte capacity is set to 256,
// far below the core's default of 1048576.
// ----------------------------------------------------------------------------
module tb_source_tokenizer_core;
    import stok_pkg::*;

    localparam int unsigned SRC_CAPACITY  = 256;
    localparam int          STALL_LIMIT   = 4000;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          PHASE_ITEMS   = 45;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] in_byte
    logic [0:0]  s_tuser  = 1'b0;    // [0] end_of_input
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;            // [19:0] start, [39:20] length, [71:40] value,
                                     // [92:72] line, zero pad
    logic [4:0]  m_tuser;            // [4:0] token_kind
    logic        m_tlast;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;
    int items_sent     = 0;

    logic [7:0] src_bytes [$];

    string kw_pool [10] = '{"let", "print", "int", "float", "string",
                            "lets", "prin", "in", "floats", "strin"};

    // ------------------------------------------------------------------------
    // Scoreboard: own lexer state plus the queue of tokens still to arrive
    // ------------------------------------------------------------------------
    class token_scoreboard;
        int unsigned capacity;
        mode_t       mode;
        int unsigned tok_begin;
        int unsigned pos;
        int unsigned line_no;
        logic [31:0] acc;
        logic [4:0]  kw_live;
        bit          slash_held;
        string       kw_word [KW_COUNT];
        token_t      batch [$];
        token_t      expected_tokens [$];
        int          errors;
        int          tokens_seen;

        function new(int unsigned cap);
            capacity    = cap;
            errors      = 0;
            tokens_seen = 0;
            kw_word[0]  = "let";
            kw_word[1]  = "print";
            kw_word[2]  = "int";
            kw_word[3]  = "float";
            kw_word[4]  = "string";
            clear_state();
        endfunction

        function void clear_state();
            mode       = MODE_IDLE;
            tok_begin  = 0;
            pos        = 0;
            line_no    = 1;
            acc        = '0;
            kw_live    = '1;
            slash_held = 1'b0;
        endfunction

        function bit is_dec(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function logic [4:0] operator_kind(logic [7:0] c);
            logic [4:0] k;
            case (c)
                "=":     k = KIND_ASSIGN;
                "+":     k = KIND_PLUS;
                "-":     k = KIND_MINUS;
                "*":     k = KIND_STAR;
                "(":     k = KIND_LPAREN;
                ")":     k = KIND_RPAREN;
                ";":     k = KIND_SEMICOLON;
                ",":     k = KIND_COMMA;
                default: k = KIND_NONE;
            endcase
            return k;
        endfunction

        function void add_token(logic [4:0] kind, int unsigned start, int unsigned len,
                                logic [31:0] val);
            token_t t;
            t.kind   = kind;
            t.start  = start[19:0];
            t.length = len[19:0];
            t.value  = val;
            t.line   = line_no[20:0];
            t.last   = 1'b0;
            batch.push_back(t);
        endfunction

        // Drop keywords that the character at the current offset rules out
        function void drop_keywords(logic [7:0] c);
            int unsigned idx;
            idx = pos - tok_begin;
            for (int k = 0; k < KW_COUNT; k++) begin
                if (!(idx < kw_word[k].len() && kw_word[k][idx] == c)) begin
                    kw_live[k] = 1'b0;
                end
            end
        endfunction

        // Emit the token under construction, if any, and fall back to idle
        function void close_token();
            int unsigned len;
            logic [4:0]  kind;
            len = pos - tok_begin;
            case (mode)
                MODE_INT:    add_token(KIND_INT, tok_begin, len, acc);
                MODE_FLOAT:  add_token(KIND_FLOAT, tok_begin, len, '0);
                MODE_STRING: add_token(KIND_STRING, tok_begin, len, '0);
                MODE_IDENT:
                begin
                    kind = KIND_IDENT;
                    // lowest keyword index wins, so scan downwards
                    for (int k = KW_COUNT - 1; k >= 0; k--) begin
                        if (kw_live[k] && len == kw_word[k].len()) begin
                            kind = 5'(KIND_KW_BASE + k);
                        end
                    end
                    add_token(kind, tok_begin, len, '0);
                end
                default: ;
            endcase
            mode = MODE_IDLE;
        endfunction

        // Lex one byte from the idle state
        function void lex_plain(logic [7:0] c);
            logic [4:0] op;
            op = operator_kind(c);
            if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
                if (c == CH_LF) begin
                    line_no++;
                end
            end else if (c == CH_SLASH) begin
                slash_held = 1'b1;
                tok_begin  = pos;
            end else if (op != KIND_NONE) begin
                add_token(op, pos, 1, '0);
            end else if (c == CH_QUOTE) begin
                mode      = MODE_STRING;
                tok_begin = pos + 1;
            end else if (is_dec(c)) begin
                mode      = MODE_INT;
                tok_begin = pos;
                acc       = {24'd0, c} - 32'd48;
            end else if (is_letter(c) || c == CH_UNDER) begin
                mode      = MODE_IDENT;
                tok_begin = pos;
                kw_live   = '1;
                drop_keywords(c);
            end else begin
                add_token(KIND_UNKNOWN, pos, 1, '0);
            end
            pos++;
        endfunction

        function void lex_byte(logic [7:0] c);
            if (slash_held) begin
                slash_held = 1'b0;
                if (c == CH_SLASH) begin
                    mode = MODE_COMMENT;
                    pos++;
                end else begin
                    add_token(KIND_SLASH, tok_begin, 1, '0);
                    lex_plain(c);
                end
            end else begin
                case (mode)
                    MODE_COMMENT:
                    begin
                        if (c == CH_LF) begin
                            mode = MODE_IDLE;
                            lex_plain(c);
                        end else begin
                            pos++;
                        end
                    end
                    MODE_STRING:
                    begin
                        if (c == CH_QUOTE) begin
                            close_token();
                        end else if (c == CH_LF) begin
                            line_no++;
                        end
                        pos++;
                    end
                    MODE_INT:
                    begin
                        if (is_dec(c)) begin
                            acc = acc * 32'd10 + ({24'd0, c} - 32'd48);
                            pos++;
                        end else if (c == CH_DOT) begin
                            mode = MODE_FLOAT;
                            pos++;
                        end else begin
                            close_token();
                            lex_plain(c);
                        end
                    end
                    MODE_FLOAT:
                    begin
                        if (is_dec(c)) begin
                            pos++;
                        end else begin
                            close_token();
                            lex_plain(c);
                        end
                    end
                    MODE_IDENT:
                    begin
                        if (is_letter(c) || is_dec(c) || c == CH_UNDER) begin
                            drop_keywords(c);
                            pos++;
                        end else begin
                            close_token();
                            lex_plain(c);
                        end
                    end
                    default: lex_plain(c);
                endcase
            end
        endfunction

        // Predict the tokens of one accepted request
        function void note_request(logic [7:0] c, bit eoi);
            token_t t;
            batch.delete();
            if (eoi) begin
                if (slash_held) begin
                    add_token(KIND_SLASH, tok_begin, 1, '0);
                    slash_held = 1'b0;
                end
                close_token();
                add_token(KIND_END, pos, 0, '0);
                clear_state();
            end else if (pos < capacity - 1) begin
                lex_byte(c);
            end
            if (batch.size() > 0) begin
                t      = batch.pop_back();
                t.last = 1'b1;
                batch.push_back(t);
            end
            foreach (batch[i]) begin
                expected_tokens.push_back(batch[i]);
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 200) begin
                $display("MISMATCH token %0d: %s", tokens_seen, msg);
            end
        endtask

        task check_token(token_t got);
            token_t want;
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected token kind %0d start %0d",
                                          got.kind, got.start));
            end else begin
                want = expected_tokens.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
                if (got.start !== want.start)
                    report_mismatch($sformatf("start %0d, want %0d", got.start, want.start));
                if (got.length !== want.length)
                    report_mismatch($sformatf("length %0d, want %0d", got.length, want.length));
                if (got.value !== want.value)
                    report_mismatch($sformatf("value %0d, want %0d", got.value, want.value));
                if (got.line !== want.line)
                    report_mismatch($sformatf("line %0d, want %0d", got.line, want.line));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
            end
        endtask
    endclass

    token_scoreboard sb = new(SRC_CAPACITY);

    source_tokenizer_core #(
        .MAX_INPUT_BYTES(SRC_CAPACITY)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stall the master side at random
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Note accepted requests, check accepted tokens, count quiet cycles
    always @(posedge clk)
    begin
        token_t got;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                sb.note_request(s_tdata, s_tuser[0]);
            end
            if (m_tvalid && m_tready) begin
                got.kind   = m_tuser;
                got.start  = m_tdata[19:0];
                got.length = m_tdata[39:20];
                got.value  = m_tdata[71:40];
                got.line   = m_tdata[92:72];
                got.last   = m_tlast;
                sb.check_token(got);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Abort when nothing moves for too long
    initial
    begin
        while (idle_cycles < STALL_LIMIT) @(posedge clk);
        $display("** source_tokenizer_core: FAILED **");
        $finish;
    end

    // Hold one request until the core takes it, after an optional gap
    task send_request(input logic [7:0] b, input bit eoi);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= b;
        s_tuser[0] <= eoi;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    // Send the queued source bytes, then the end mark
    task send_source();
        foreach (src_bytes[i]) begin
            send_request(src_bytes[i], 1'b0);
        end
        send_request(8'($urandom_range(255)), 1'b1);
        src_bytes.delete();
    endtask

    task add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            src_bytes.push_back(s[i]);
        end
    endtask

    function logic [7:0] pick_from(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    // Append one random token, mostly well-formed, sometimes noise
    task add_random_token(input bit allow_open);
        int n;
        case ($urandom_range(10))
            0: add_text(kw_pool[$urandom_range(9)]);
            1:
            begin
                src_bytes.push_back(pick_from("abcxyzLPQ_"));
                n = $urandom_range(6);
                repeat (n) src_bytes.push_back(pick_from("aeinrstfloZ09_"));
            end
            2:
            begin
                n = $urandom_range(1, 12);
                repeat (n) src_bytes.push_back(pick_from("0123456789"));
            end
            3:
            begin
                n = $urandom_range(1, 3);
                repeat (n) src_bytes.push_back(pick_from("0123456789"));
                src_bytes.push_back(CH_DOT);
                n = $urandom_range(3);
                repeat (n) src_bytes.push_back(pick_from("0123456789"));
                if ($urandom_range(3) == 0) src_bytes.push_back(CH_DOT);
            end
            4:
            begin
                src_bytes.push_back(CH_QUOTE);
                n = $urandom_range(5);
                repeat (n) begin
                    if ($urandom_range(5) == 0) src_bytes.push_back(CH_LF);
                    else src_bytes.push_back(8'($urandom_range(8'h23, 8'hFF)));
                end
                // leave the string open now and then at the end of a source
                if (!(allow_open && $urandom_range(2) == 0)) src_bytes.push_back(CH_QUOTE);
            end
            5: src_bytes.push_back(pick_from("=+-*/();,"));
            6:
            begin
                add_text("//");
                n = $urandom_range(5);
                repeat (n) src_bytes.push_back(8'($urandom_range(8'h0B, 8'hFF)));
                src_bytes.push_back(CH_LF);
            end
            7:
            begin
                n = $urandom_range(1, 3);
                repeat (n) src_bytes.push_back(pick_from(" \t\r\n"));
            end
            8: src_bytes.push_back(8'($urandom_range(255)));
            9:
            begin
                src_bytes.push_back(CH_SLASH);
                src_bytes.push_back(8'($urandom_range(255)));
            end
            default: add_text("let x = 10;\n");
        endcase
        // separate tokens only some of the time
        if ($urandom_range(1) == 0) src_bytes.push_back(pick_from("  \t\n"));
    endtask

    task make_random_source(input int n_tokens);
        for (int i = 0; i < n_tokens; i++) begin
            add_random_token(i == n_tokens - 1);
        end
    endtask

    task run_phase(input int idle_pct, input int stall_pct);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target) begin
            make_random_source($urandom_range(1, 8));
            send_source();
        end
    endtask

    initial
    begin
        // Hold reset at the start, then release it
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: operators with a lone slash, non-ASCII and zero bytes,
        // trailing and second dot, a comment, a keyword, an open string
        add_text("=+-*/();,");
        src_bytes.push_back(8'hFF);
        src_bytes.push_back(8'h00);
        add_text("7..//c\nprint \"ab");
        send_source();
        // empty source, then a slash held at the end mark
        send_source();
        add_text("a/");
        send_source();

        run_phase(0, 0);
        run_phase(86, 0);
        run_phase(0, 86);
        run_phase(32, 32);

        // Drain the output queue
        s_tvalid <= 1'b0;
        while (sb.expected_tokens.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.expected_tokens.size() != 0) begin
            sb.report_mismatch("tokens still outstanding at the end");
        end

        if (sb.errors == 0) begin
            $display("** source_tokenizer_core: PASSED **");
        end else begin
            $display("** source_tokenizer_core: FAILED **");
        end
        $finish;
    end

endmodule
